// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, request codes and cell constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int CELLS        = COLUMNS * ROWS;
   localparam int SCROLL_CELLS = COLUMNS * (ROWS - 1);
   localparam int ADDR_W       = $clog2(CELLS);
   localparam int CELL_W       = 16;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0]        NEWLINE_CHAR = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F00;

endpackage

// ===== rtl/core/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text screen of COLUMNS x ROWS cells in a RAM, with a cursor, scroll and clear.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Word
//  req_    | in        | req_valid/req_ready  | kind, ch, fg/bg color, col, row
//  rsp_    | out       | rsp_valid/rsp_ready  | cell value, cursor, scrolled
//
//  A put, or any item without scroll, goes through S_DONE; an on-screen read also
//  passes S_READ because of the registered RAM read. A scroll adds a copy pass (one
//  cell copy per cycle on the single RAM port pair, then the bottom row blanked),
//  and a clear adds a pass over every cell. After reset a clearing pass over every
//  cell runs with req_ready low. A new word is taken while a result waits.
// ----------------------------------------------------------------------------
module text_console_writer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic [7:0]                 req_ch,
   input  logic [3:0]                 req_fg_color,
   input  logic [3:0]                 req_bg_color,
   input  logic [6:0]                 req_col,
   input  logic [4:0]                 req_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tcw_pkg::CELL_W-1:0] rsp_cell_value,
   output logic [6:0]                 rsp_cursor_col,
   output logic [4:0]                 rsp_cursor_row,
   output logic                       rsp_scrolled
);
   import tcw_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_READ   = 7'b0000010,
      S_SCROLL = 7'b0000100,
      S_BLANK  = 7'b0001000,
      S_CLEAR  = 7'b0010000,
      S_DONE   = 7'b0100000,
      S_WAIT   = 7'b1000000
   } state_type;

   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(SCROLL_CELLS);
   localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [6:0]        cur_col_ff, cur_col_in;
   logic [4:0]        cur_row_ff, cur_row_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              scrolled_ff, scrolled_in;
   logic              clear_rsp_ff, clear_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic [4:0]        rsp_row_ff, rsp_row_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   logic              accept;
   logic              in_range;
   logic              is_newline;
   logic [ADDR_W-1:0] req_addr;
   logic [7:0]        col_inc;
   logic [5:0]        row_inc;
   logic              out_free;

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELLS)
   ) u_screen (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = ({1'b0, req_col} < 8'(COLUMNS)) && ({1'b0, req_row} < 6'(ROWS));
   assign is_newline = (req_ch == NEWLINE_CHAR);
   assign req_addr  = ADDR_W'(ADDR_W'(req_row) * ROW_STEP) + ADDR_W'(req_col);
   assign col_inc   = {1'b0, cur_col_ff} + 8'd1;
   assign row_inc   = {1'b0, cur_row_ff} + 6'd1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cell_in      = cell_ff;
      scrolled_in  = scrolled_ff;
      clear_rsp_in = clear_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      ram_we       = 1'b0;
      ram_waddr    = req_addr;
      ram_wdata    = {req_bg_color, req_fg_color, req_ch};
      ram_raddr    = req_addr;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cell_in     = '0;
               scrolled_in = 1'b0;
               state_in    = S_DONE;
               case (req_kind)
                  KIND_PUT: begin
                     ram_we = !is_newline && in_range;
                     // The cursor moves from its own position, not from col and row.
                     if (is_newline || (col_inc >= 8'(COLUMNS))) begin
                        cur_col_in = '0;
                        if (row_inc >= 6'(ROWS)) begin
                           cur_row_in  = 5'(ROWS - 1);
                           scrolled_in = 1'b1;
                           cnt_in      = '0;
                           state_in    = S_SCROLL;
                        end else begin
                           cur_row_in = row_inc[4:0];
                        end
                     end else begin
                        cur_col_in = col_inc[6:0];
                     end
                  end
                  KIND_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     cnt_in       = '0;
                     clear_rsp_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  KIND_READ: begin
                     if (in_range) begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            cell_in  = ram_rdata;
            state_in = S_DONE;
         end
         S_SCROLL: begin
            // Read one row ahead and write the previous cycle's data one cell behind.
            ram_raddr = (cnt_ff == SCROLL_LAST) ? cnt_ff : cnt_ff + ROW_STEP;
            ram_we    = (cnt_ff != '0);
            ram_waddr = cnt_ff - ADDR_W'(1);
            ram_wdata = ram_rdata;
            if (cnt_ff == SCROLL_LAST) begin
               state_in = S_BLANK;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = BLANK_CELL;
            if (cnt_ff == CELL_LAST) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = BLANK_CELL;
            if (cnt_ff == CELL_LAST) begin
               clear_rsp_in = 1'b0;
               state_in     = clear_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         S_DONE, S_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               rsp_scr_in   = scrolled_ff;
               state_in     = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         clear_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         clear_rsp_ff <= clear_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cell_ff     <= cell_in;
      scrolled_ff <= scrolled_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_col_ff} < 8'(COLUMNS)) && ({1'b0, cur_row_ff} < 6'(ROWS)))
      else $error("cursor left the screen");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr <= CELL_LAST))
      else $error("screen write beyond the last cell");

   a_scroll_then_blank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL) && (cnt_ff == SCROLL_LAST) |=> (state_ff == S_BLANK))
      else $error("scroll copy did not hand over to bottom row blanking");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_scr_ff |->
         (rsp_col_ff == '0) && (rsp_row_ff == 5'(ROWS - 1)))
      else $error("scrolled word without cursor on the last row");

endmodule

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/text_console_writer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request and reply channels of the text console writer. It keeps
// its own copy of the screen and the cursor and predicts the reply to every
// accepted word. Each accepted reply is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module text_console_writer_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic [7:0]                 req_ch,
   input  logic [3:0]                 req_fg_color,
   input  logic [3:0]                 req_bg_color,
   input  logic [6:0]                 req_col,
   input  logic [4:0]                 req_row,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [tcw_pkg::CELL_W-1:0] rsp_cell_value,
   input  logic [6:0]                 rsp_cursor_col,
   input  logic [4:0]                 rsp_cursor_row,
   input  logic                       rsp_scrolled,
   output int                         mismatches,
   output int                         pending,
   output int                         replies_checked,
   output int                         scrolls_seen
);
   import tcw_pkg::*;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [6:0]        cursor_col;
      logic [4:0]        cursor_row;
      logic              scrolled;
   } console_reply_type;

   logic [CELL_W-1:0] screen [CELLS];
   int                cur_col;
   int                cur_row;
   int                err_count;
   int                checked_count;
   int                scroll_count;
   console_reply_type replies_due [$];

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) begin
         screen[i] = BLANK_CELL;
      end
   endfunction

   // Moves the cursor to the start of the next row and scrolls when it falls
   // off the bottom. Returns 1 when the screen scrolled.
   function automatic logic next_row();
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS) begin
         return 1'b0;
      end
      for (int i = 0; i < SCROLL_CELLS; i++) begin
         screen[i] = screen[i + COLUMNS];
      end
      for (int i = SCROLL_CELLS; i < CELLS; i++) begin
         screen[i] = BLANK_CELL;
      end
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   function automatic console_reply_type predict_reply(
      logic [1:0] kind, logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
      logic [6:0] col, logic [4:0] row);
      console_reply_type r;
      logic              on_screen;
      r = '0;
      on_screen = (int'(col) < COLUMNS) && (int'(row) < ROWS);
      case (kind)
         KIND_PUT: begin
            if (ch == NEWLINE_CHAR) begin
               r.scrolled = next_row();
            end else begin
               // The cell position comes from the word, the cursor moves on its own.
               if (on_screen) begin
                  screen[int'(row) * COLUMNS + int'(col)] = {bg, fg, ch};
               end
               cur_col++;
               if (cur_col >= COLUMNS) begin
                  r.scrolled = next_row();
               end
            end
         end
         KIND_CLEAR: begin
            blank_screen();
            cur_col = 0;
            cur_row = 0;
         end
         KIND_READ: begin
            if (on_screen) begin
               r.cell_value = screen[int'(row) * COLUMNS + int'(col)];
            end
         end
         default: begin
         end
      endcase
      r.cursor_col = cur_col[6:0];
      r.cursor_row = cur_row[4:0];
      return r;
   endfunction

   function automatic void report_field(string name, logic [CELL_W-1:0] want,
                                        logic [CELL_W-1:0] got);
      err_count++;
      if (err_count <= 40) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      console_reply_type got;
      console_reply_type want;
      if (reset) begin
         blank_screen();
         cur_col       = 0;
         cur_row       = 0;
         err_count     = 0;
         checked_count = 0;
         scroll_count  = 0;
         replies_due.delete();
      end else begin
         // Retire the oldest prediction before adding the one for a new word.
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cell_value, rsp_cursor_col, rsp_cursor_row, rsp_scrolled};
            if (replies_due.size() == 0) begin
               err_count++;
               $display("%0t: reply 0x%0h arrived with no word waiting", $time, got);
            end else begin
               want = replies_due.pop_front();
               checked_count++;
               if (got.cell_value !== want.cell_value) begin
                  report_field("cell_value", want.cell_value, got.cell_value);
               end
               if (got.cursor_col !== want.cursor_col) begin
                  report_field("cursor_col", CELL_W'(want.cursor_col),
                               CELL_W'(got.cursor_col));
               end
               if (got.cursor_row !== want.cursor_row) begin
                  report_field("cursor_row", CELL_W'(want.cursor_row),
                               CELL_W'(got.cursor_row));
               end
               if (got.scrolled !== want.scrolled) begin
                  report_field("scrolled", CELL_W'(want.scrolled), CELL_W'(got.scrolled));
               end
            end
         end
         if (req_valid && req_ready) begin
            want = predict_reply(req_kind, req_ch, req_fg_color, req_bg_color,
                                 req_col, req_row);
            if (want.scrolled) begin
               scroll_count++;
            end
            replies_due.push_back(want);
         end
      end
      pending         <= replies_due.size();
      mismatches      <= err_count;
      replies_checked <= checked_count;
      scrolls_seen    <= scroll_count;
   end

endmodule

// ===== tb/text_console_writer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Drives character puts, newlines, clears and cell reads into the console
// writer: a directed opening, then lines of text, read-back bursts, newline
// runs that force scrolling, and raw noise, with random stalls on both sides.
// The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int         HALF_PERIOD  = 6;
   localparam int         CLK_PERIOD   = 2 * HALF_PERIOD;
   localparam int         RANDOM_WORDS = 1500;
   localparam int         CALM_WORDS   = 150;
   localparam int         HOT_SLOTS    = 16;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   // Worst case: every word scrolls and waits out the longest stall on each side.
   localparam longint LIMIT_CYCLES =
      3 * (longint'(CELLS) + longint'(RANDOM_WORDS + 100) * longint'(CELLS + 20));

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic [3:0] fg;
      logic [3:0] bg;
      logic [6:0] col;
      logic [4:0] row;
   } console_word_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_kind;
   logic [7:0]        req_ch;
   logic [3:0]        req_fg_color;
   logic [3:0]        req_bg_color;
   logic [6:0]        req_col;
   logic [4:0]        req_row;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   logic [CELL_W-1:0] rsp_cell_value;
   logic [6:0]        rsp_cursor_col;
   logic [4:0]        rsp_cursor_row;
   logic              rsp_scrolled;

   int mismatches;
   int pending;
   int replies_checked;
   int scrolls_seen;

   int calm       = 0;
   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;
   int words_sent = 0;
   int puts_sent  = 0;
   int reads_sent = 0;
   int clears_sent = 0;
   int hot_col [HOT_SLOTS];
   int hot_row [HOT_SLOTS];
   int hot_next = 0;

   always #(HALF_PERIOD) clock = ~clock;

   text_console_writer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_ch         (req_ch),
      .req_fg_color   (req_fg_color),
      .req_bg_color   (req_bg_color),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled)
   );

   text_console_writer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_ch          (req_ch),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .req_col         (req_col),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_cursor_col  (rsp_cursor_col),
      .rsp_cursor_row  (rsp_cursor_row),
      .rsp_scrolled    (rsp_scrolled),
      .mismatches      (mismatches),
      .pending         (pending),
      .replies_checked (replies_checked),
      .scrolls_seen    (scrolls_seen)
   );

   // Reply side back-pressure: random stall bursts, none in the calm tail.
   always @(posedge clock) begin
      if (reset || calm != 0) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(1, 7);
         rsp_ready  <= 1'b0;
      end
   end

   function automatic console_word_type make_word(logic [1:0] kind, logic [7:0] ch,
      logic [3:0] fg, logic [3:0] bg, logic [6:0] col, logic [4:0] row);
      console_word_type w;
      w = '{kind: kind, ch: ch, fg: fg, bg: bg, col: col, row: row};
      return w;
   endfunction

   // Called at a rising edge; returns at the edge where the word was taken, or later after a random idle gap.
   task automatic send_word(console_word_type w);
      req_valid    <= 1'b1;
      req_kind     <= w.kind;
      req_ch       <= w.ch;
      req_fg_color <= w.fg;
      req_bg_color <= w.bg;
      req_col      <= w.col;
      req_row      <= w.row;
      do begin
         @(posedge clock);
      end while (!req_ready);
      words_sent++;
      case (w.kind)
         KIND_PUT: begin
            puts_sent++;
            if (w.ch != NEWLINE_CHAR && int'(w.col) < COLUMNS && int'(w.row) < ROWS) begin
               hot_col[hot_next] = int'(w.col);
               hot_row[hot_next] = int'(w.row);
               hot_next = (hot_next + 1) % HOT_SLOTS;
            end
         end
         KIND_READ:  reads_sent++;
         KIND_CLEAR: clears_sent++;
         default: begin
         end
      endcase
      if (calm == 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Holds the request side until every predicted reply has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int               sel;
      int               r;
      int               c;
      int               n;
      int               slot;
      int               goal;
      int               halfway;
      bit               held;
      logic [3:0]       fg;
      logic [3:0]       bg;
      console_word_type w;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = KIND_PUT;
      req_ch       = 8'd0;
      req_fg_color = 4'd0;
      req_bg_color = 4'd0;
      req_col      = 7'd0;
      req_row      = 5'd0;
      held         = 1'b0;
      for (int i = 0; i < HOT_SLOTS; i++) begin
         hot_col[i] = 0;
         hot_row[i] = 0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: corners, extreme colors and characters, off-screen
      // positions, newline, the unused kind and a clear.
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0));
      send_word(make_word(KIND_PUT, 8'h41, 4'hF, 4'h0, 7'd0, 5'd0));
      send_word(make_word(KIND_PUT, 8'hFF, 4'h0, 4'hF, 7'd79, 5'd24));
      send_word(make_word(KIND_PUT, 8'h00, 4'hF, 4'hF, 7'd79, 5'd0));
      send_word(make_word(KIND_PUT, 8'h80, 4'h5, 4'hA, 7'd0, 5'd24));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0));
      send_word(make_word(KIND_READ, 8'hFF, 4'hF, 4'hF, 7'd79, 5'd24));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd79, 5'd0));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd24));
      send_word(make_word(KIND_PUT, 8'h7E, 4'h3, 4'hC, 7'd127, 5'd0));
      send_word(make_word(KIND_PUT, 8'h21, 4'hC, 4'h3, 7'd0, 5'd31));
      send_word(make_word(KIND_PUT, 8'h22, 4'h1, 4'h2, 7'd80, 5'd25));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd80, 5'd0));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd127, 5'd31));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd25));
      send_word(make_word(KIND_PUT, NEWLINE_CHAR, 4'h9, 4'h6, 7'd0, 5'd0));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0));
      send_word(make_word(KIND_UNUSED, 8'hFF, 4'hF, 4'hF, 7'd127, 5'd31));
      send_word(make_word(KIND_CLEAR, 8'hFF, 4'hF, 4'hF, 7'd127, 5'd31));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd79, 5'd24));
      send_word(make_word(KIND_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0));
      drain_replies();

      goal    = words_sent + RANDOM_WORDS;
      halfway = words_sent + RANDOM_WORDS / 2;
      while (words_sent < goal) begin
         if (!held && words_sent >= halfway) begin
            drain_replies();
            held = 1'b1;
         end
         if (calm == 0 && words_sent >= goal - CALM_WORDS) begin
            calm <= 1;
         end
         gap_pct   <= 15 * $urandom_range(0, 2);
         stall_pct <= 15 * $urandom_range(0, 2);

         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            // A run of characters along one row, often near the bottom.
            r  = ($urandom_range(0, 1) != 0) ? $urandom_range(20, 24) : $urandom_range(0, 24);
            c  = $urandom_range(0, 79);
            n  = $urandom_range(1, 40);
            fg = 4'($urandom_range(0, 15));
            bg = 4'($urandom_range(0, 15));
            for (int i = 0; i < n && c + i < COLUMNS; i++) begin
               send_word(make_word(KIND_PUT, 8'($urandom_range(0, 255)), fg, bg,
                                   7'(c + i), 5'(r)));
            end
            if ($urandom_range(0, 1) != 0) begin
               send_word(make_word(KIND_PUT, NEWLINE_CHAR, fg, bg, 7'(c), 5'(r)));
            end
         end else if (sel < 70) begin
            // Read back recent writes, or the row above them to see scrolled text.
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               slot = $urandom_range(0, HOT_SLOTS - 1);
               c = hot_col[slot];
               r = hot_row[slot];
               if ($urandom_range(0, 3) == 0 && r > 0) begin
                  r = r - 1;
               end else if ($urandom_range(0, 9) == 0) begin
                  c = $urandom_range(0, COLUMNS - 1);
                  r = $urandom_range(0, ROWS - 1);
               end
               send_word(make_word(KIND_READ, 8'($urandom_range(0, 255)),
                                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                   7'(c), 5'(r)));
            end
         end else if (sel < 85) begin
            // A run of newlines pushes the cursor toward the bottom and scrolls once it gets there.
            n = $urandom_range(5, 40);
            for (int i = 0; i < n; i++) begin
               send_word(make_word(KIND_PUT, NEWLINE_CHAR, 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                                   5'($urandom_range(0, 31))));
            end
         end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               w = make_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
               send_word(w);
            end
         end
      end

      drain_replies();
      repeat (10) @(posedge clock);
      $display("Sent %0d words: %0d puts, %0d reads, %0d clears, the rest unused kinds.",
               words_sent, puts_sent, reads_sent, clears_sent);
      $display("Compared %0d replies; %0d of the words scrolled the screen.",
               replies_checked, scrolls_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("Run did not complete within %0d cycles.", LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
